// ----- design/avc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_pkg
// Types, codes and letter helpers for the Cyrillic autokey Vigenere unit.
// ----------------------------------------------------------------------------
package avc_pkg;

    localparam int KEY_MAX_DEF = 64;
    localparam int ALPHA       = 33;
    localparam int IDX_W       = 6;
    localparam int CODE_W      = 16;

    localparam logic [CODE_W-1:0] CODE_IO_UP    = 16'd1025;
    localparam logic [CODE_W-1:0] CODE_IO_LO    = 16'd1105;
    localparam logic [CODE_W-1:0] CODE_UP_FIRST = 16'd1040;
    localparam logic [CODE_W-1:0] CODE_UP_LAST  = 16'd1071;
    localparam logic [CODE_W-1:0] CODE_LO_FIRST = 16'd1072;
    localparam logic [CODE_W-1:0] CODE_LO_LAST  = 16'd1103;
    localparam logic [IDX_W-1:0]  IDX_IO        = 6'd6;
    localparam logic [CODE_W-1:0] CASE_OFFSET   = 16'd32;

    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_KEY   = 2'd1;
    localparam logic [1:0] FN_TEXT  = 2'd2;

    typedef enum logic [2:0] {
        ST_CIPHERED     = 3'd0,
        ST_PASSED       = 3'd1,
        ST_KEY_STORED   = 3'd2,
        ST_KEY_REJECTED = 3'd3,
        ST_NO_KEY       = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_FIXED  = 2'd0,
        OP_KEY    = 2'd1,
        OP_CIPHER = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]        func;
        logic [CODE_W-1:0] in_code;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        t_status           status;
    } t_out_item;

    typedef struct packed {
        logic             is_letter;
        logic             lower;
        logic [IDX_W-1:0] idx;
    } t_letter;

    // request handed from the decode stage to the ring stage
    typedef struct packed {
        t_op               op;
        logic [CODE_W-1:0] code;
        t_status           status;
        logic [IDX_W-1:0]  idx;
        logic              lower;
        logic              dec;
    } t_s1_req;

    localparam int APB_AW = 3;

    localparam logic REG_DECRYPT   = 1'b0;
    localparam logic REG_KEEP_CASE = 1'b1;

    function automatic t_letter decode_letter(input logic [CODE_W-1:0] code);
        t_letter           res;
        logic [CODE_W-1:0] off;
        res = '0;
        off = '0;
        if (code == CODE_IO_UP) begin
            res.is_letter = 1'b1;
            res.idx       = IDX_IO;
        end else if (code == CODE_IO_LO) begin
            res.is_letter = 1'b1;
            res.lower     = 1'b1;
            res.idx       = IDX_IO;
        end else if (code >= CODE_LO_FIRST && code <= CODE_LO_LAST) begin
            res.is_letter = 1'b1;
            res.lower     = 1'b1;
            off           = code - CODE_LO_FIRST;
        end else if (code >= CODE_UP_FIRST && code <= CODE_UP_LAST) begin
            res.is_letter = 1'b1;
            off           = code - CODE_UP_FIRST;
        end
        if (res.is_letter && code != CODE_IO_UP && code != CODE_IO_LO) begin
            // io sits between ie and zhe
            if (off[IDX_W-1:0] < IDX_IO)
                res.idx = off[IDX_W-1:0];
            else
                res.idx = off[IDX_W-1:0] + 6'd1;
        end
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] index_code(input logic [IDX_W-1:0] idx,
                                                     input logic lower);
        logic [CODE_W-1:0] up;
        if (idx == IDX_IO)
            return lower ? CODE_IO_LO : CODE_IO_UP;
        if (idx < IDX_IO)
            up = CODE_UP_FIRST + {10'd0, idx};
        else
            up = CODE_UP_FIRST - 16'd1 + {10'd0, idx};
        return lower ? up + CASE_OFFSET : up;
    endfunction

endpackage

// ----- design/avc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module avc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            r_mem[i_wr_addr] <= i_wr_data;
        // read returns the old contents on a same-address write
        if (i_rd_en)
            r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/avc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_front
// Request decode, key length and ring position, ring read issue.
// ----------------------------------------------------------------------------
module avc_front #(
    parameter int KEY_MAX = avc_pkg::KEY_MAX_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_load,
    input  avc_pkg::t_in_item                         i_item,
    input  logic                                      i_decrypt,
    input  logic                                      i_keep_case,
    output avc_pkg::t_s1_req                          o_req,
    output logic [(KEY_MAX > 1 ? $clog2(KEY_MAX) : 1)-1:0] o_addr,
    output logic                                      o_rd_en
);

    localparam int PW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LW = $clog2(KEY_MAX + 1);

    logic [LW-1:0]    r_key_len, n_key_len;
    logic [PW-1:0]    r_ring_pos, n_ring_pos;
    avc_pkg::t_letter w_let;
    logic [PW-1:0]    w_pos_eff;
    logic [LW-1:0]    w_pos_inc;

    always_comb begin
        w_let      = avc_pkg::decode_letter(i_item.in_code);
        n_key_len  = r_key_len;
        n_ring_pos = r_ring_pos;
        o_addr     = '0;
        o_req      = '0;
        o_req.op   = avc_pkg::OP_FIXED;
        o_req.status = avc_pkg::ST_KEY_REJECTED;
        o_req.idx  = w_let.idx;
        o_req.lower = w_let.lower & i_keep_case;
        o_req.dec  = i_decrypt;
        // position falls back to zero when it lies at or past the key length
        w_pos_eff  = (LW'(r_ring_pos) >= r_key_len) ? '0 : r_ring_pos;
        w_pos_inc  = LW'(w_pos_eff) + LW'(1);
        case (i_item.func)
            avc_pkg::FN_CLEAR: begin
                n_key_len    = '0;
                n_ring_pos   = '0;
                o_req.status = avc_pkg::ST_KEY_STORED;
            end
            avc_pkg::FN_KEY: begin
                if (w_let.is_letter && r_key_len < LW'(KEY_MAX)) begin
                    o_req.op     = avc_pkg::OP_KEY;
                    o_req.status = avc_pkg::ST_KEY_STORED;
                    o_addr       = r_key_len[PW-1:0];
                    n_key_len    = r_key_len + LW'(1);
                end
            end
            avc_pkg::FN_TEXT: begin
                if (!w_let.is_letter) begin
                    o_req.code   = i_item.in_code;
                    o_req.status = avc_pkg::ST_PASSED;
                end else if (r_key_len == '0) begin
                    o_req.code   = i_item.in_code;
                    o_req.status = avc_pkg::ST_NO_KEY;
                end else begin
                    o_req.op     = avc_pkg::OP_CIPHER;
                    o_req.status = avc_pkg::ST_CIPHERED;
                    o_addr       = w_pos_eff;
                    n_ring_pos   = (w_pos_inc >= r_key_len) ? '0 : w_pos_inc[PW-1:0];
                end
            end
            default: begin
            end
        endcase
        o_rd_en = i_load && (o_req.op == avc_pkg::OP_CIPHER);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len  <= '0;
            r_ring_pos <= '0;
        end else if (i_load) begin
            r_key_len  <= n_key_len;
            r_ring_pos <= n_ring_pos;
        end
    end

endmodule

// ----- design/avc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_back
// Ring stage: key select with forwarding, mod-33 add or subtract, write back, output reg.
// ----------------------------------------------------------------------------
module avc_back #(
    parameter int KEY_MAX = avc_pkg::KEY_MAX_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_load,
    input  avc_pkg::t_s1_req                          i_req,
    input  logic [(KEY_MAX > 1 ? $clog2(KEY_MAX) : 1)-1:0] i_addr,
    input  logic [avc_pkg::IDX_W-1:0]                 i_rd_data,
    input  logic                                      i_out_ready,
    output logic                                      o_ready,
    output logic                                      o_wr_en,
    output logic [(KEY_MAX > 1 ? $clog2(KEY_MAX) : 1)-1:0] o_wr_addr,
    output logic [avc_pkg::IDX_W-1:0]                 o_wr_data,
    output logic                                      o_out_valid,
    output avc_pkg::t_out_item                        o_out_data
);

    localparam int PW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int IW = avc_pkg::IDX_W;

    logic               r_s1_vld;
    avc_pkg::t_s1_req   r_s1_req;
    logic [PW-1:0]      r_s1_addr;
    logic               r_fwd_hit;
    logic [IW-1:0]      r_fwd_data;
    logic               r_out_vld;
    avc_pkg::t_out_item r_out_data, n_out_data;
    logic               w_adv;
    logic [IW-1:0]      w_key;
    logic [IW:0]        w_sum;
    logic [IW-1:0]      w_c;

    assign w_adv   = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_ready = !r_s1_vld || w_adv;

    always_comb begin
        // a write landing at the same edge as the read is not in the ram data
        w_key = r_fwd_hit ? r_fwd_data : i_rd_data;
        if (r_s1_req.dec)
            w_sum = {1'b0, r_s1_req.idx} + (IW + 1)'(avc_pkg::ALPHA) - {1'b0, w_key};
        else
            w_sum = {1'b0, r_s1_req.idx} + {1'b0, w_key};
        if (w_sum >= (IW + 1)'(avc_pkg::ALPHA))
            w_sum = w_sum - (IW + 1)'(avc_pkg::ALPHA);
        w_c = w_sum[IW-1:0];

        n_out_data.out_code = r_s1_req.code;
        n_out_data.status   = r_s1_req.status;
        o_wr_en   = 1'b0;
        o_wr_addr = r_s1_addr;
        o_wr_data = r_s1_req.idx;
        case (r_s1_req.op)
            avc_pkg::OP_KEY: begin
                o_wr_en = w_adv;
            end
            avc_pkg::OP_CIPHER: begin
                o_wr_en   = w_adv;
                o_wr_data = r_s1_req.dec ? w_c : r_s1_req.idx;
                n_out_data.out_code = avc_pkg::index_code(w_c, r_s1_req.lower);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_load)
                r_s1_vld <= 1'b1;
            else if (w_adv)
                r_s1_vld <= 1'b0;
            if (w_adv)
                r_out_vld <= 1'b1;
            else if (i_out_ready)
                r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_req   <= i_req;
            r_s1_addr  <= i_addr;
            r_fwd_hit  <= o_wr_en && (o_wr_addr == i_addr);
            r_fwd_data <= o_wr_data;
        end
        if (w_adv)
            r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

// ----- design/autokey_vigenere_cyrillic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autokey_vigenere_cyrillic_unit
// Autokey Vigenere cipher over the 33-letter Russian alphabet, key ring in RAM.
// ----------------------------------------------------------------------------
//  channel   signals                                   moves
//  in        i_in_valid / o_in_ready / i_in_data       one request per item
//  out       o_out_valid / i_out_ready / o_out_data    one result per item
//  config    psel penable pwrite paddr pwdata prdata   decrypt_mode @0, keep_case @4
//
//  one item per cycle while the output is not stalled; a result passes the ring stage
//  and then the output register; the single ring RAM read-modify-write sets the rate,
//  same-entry back-to-back accesses are covered by forwarding the pending write
//  reset clears key length, ring position and config; the ring RAM is not cleared
//  a stalled output holds its result while one more request waits in the ring stage
// ----------------------------------------------------------------------------
module autokey_vigenere_cyrillic_unit #(
    parameter int KEY_MAX = avc_pkg::KEY_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  avc_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output avc_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [avc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int PW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic                      r_decrypt;
    logic                      r_keep_case;
    logic                      w_load;
    avc_pkg::t_s1_req          w_req;
    logic [PW-1:0]             w_addr;
    logic                      w_rd_en;
    logic [avc_pkg::IDX_W-1:0] w_rd_data;
    logic                      w_wr_en;
    logic [PW-1:0]             w_wr_addr;
    logic [avc_pkg::IDX_W-1:0] w_wr_data;

    assign pready = 1'b1;
    assign prdata = {31'd0, (paddr[2] == avc_pkg::REG_KEEP_CASE) ? r_keep_case : r_decrypt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt   <= 1'b0;
            r_keep_case <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == avc_pkg::REG_DECRYPT)
                r_decrypt <= pwdata[0];
            else
                r_keep_case <= pwdata[0];
        end
    end

    assign w_load = i_in_valid && o_in_ready;

    avc_front #(.KEY_MAX(KEY_MAX)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_item      (i_in_data),
        .i_decrypt   (r_decrypt),
        .i_keep_case (r_keep_case),
        .o_req       (w_req),
        .o_addr      (w_addr),
        .o_rd_en     (w_rd_en)
    );

    avc_ram #(.WIDTH(avc_pkg::IDX_W), .DEPTH(KEY_MAX)) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    avc_back #(.KEY_MAX(KEY_MAX)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_req       (w_req),
        .i_addr      (w_addr),
        .i_rd_data   (w_rd_data),
        .i_out_ready (i_out_ready),
        .o_ready     (o_in_ready),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- design/avc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_checker
// Port-level checks for the autokey Vigenere unit, bound to the top level.
// ----------------------------------------------------------------------------
module avc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input avc_pkg::t_out_item o_out_data
);

    // a result must not be dropped or changed while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // ciphered results are always Cyrillic letters
    a_cipher_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == avc_pkg::ST_CIPHERED |->
            o_out_data.out_code == avc_pkg::CODE_IO_UP ||
            o_out_data.out_code == avc_pkg::CODE_IO_LO ||
            (o_out_data.out_code >= avc_pkg::CODE_UP_FIRST &&
             o_out_data.out_code <= avc_pkg::CODE_LO_LAST))
        else $error("ciphered code outside the alphabet");

    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == avc_pkg::ST_KEY_STORED ||
                        o_out_data.status == avc_pkg::ST_KEY_REJECTED) |->
            o_out_data.out_code == '0)
        else $error("key result with nonzero code");

endmodule

bind autokey_vigenere_cyrillic_unit avc_checker u_avc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- tb/sv/autokey_vigenere_cyrillic_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autokey_vigenere_cyrillic_unit_tb
// Self-checking bench for the Cyrillic autokey Vigenere unit. A short table of
// directed requests covers the field extremes, key handling, case rules and
// pass-through codes. Random messages follow: usually a clear, a key, then a text
// stream with mid-message key appends and noise. Messages run under all four
// mode settings and three idle patterns. Results are compared against typed table
// values where given, else against a cycle-free model of the cipher in the bench.
// ----------------------------------------------------------------------------
module autokey_vigenere_cyrillic_unit_tb;
    import avc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_ROWS      = 25;
    localparam int N_SEGS      = 6;
    localparam int SEG_ITEMS   = 135;
    localparam int SHOW_MAX    = 10;

    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic [APB_AW-1:0] ADDR_DECRYPT   = {1'b0, REG_DECRYPT, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_KEEP_CASE = {1'b0, REG_KEEP_CASE, 2'b00};

    typedef struct packed {
        logic [1:0]        func;
        logic [CODE_W-1:0] code;
        logic              fixed;
        logic [CODE_W-1:0] want_code;
        t_status           want_status;
    } t_row;

    // typed results only where they follow directly from the rules
    t_row plan [N_ROWS] = '{
        '{FN_TEXT,   16'd1040,  1'b1, 16'd1040,  ST_NO_KEY},
        '{FN_TEXT,   16'd0,     1'b1, 16'd0,     ST_PASSED},
        '{FN_TEXT,   16'hFFFF,  1'b1, 16'hFFFF,  ST_PASSED},
        '{FN_KEY,    16'd1039,  1'b1, 16'd0,     ST_KEY_REJECTED},
        '{FN_UNUSED, 16'hFFFF,  1'b1, 16'd0,     ST_KEY_REJECTED},
        '{FN_CLEAR,  16'h5555,  1'b1, 16'd0,     ST_KEY_STORED},
        '{FN_KEY,    16'd1025,  1'b1, 16'd0,     ST_KEY_STORED},
        '{FN_KEY,    16'd1105,  1'b1, 16'd0,     ST_KEY_STORED},
        '{FN_KEY,    16'd1040,  1'b1, 16'd0,     ST_KEY_STORED},
        '{FN_KEY,    16'd1103,  1'b1, 16'd0,     ST_KEY_STORED},
        '{FN_TEXT,   16'd1071,  1'b0, 16'd0,     ST_CIPHERED},
        '{FN_TEXT,   16'd1072,  1'b0, 16'd0,     ST_CIPHERED},
        '{FN_TEXT,   16'd1104,  1'b1, 16'd1104,  ST_PASSED},
        '{FN_TEXT,   16'd1024,  1'b1, 16'd1024,  ST_PASSED},
        '{FN_TEXT,   16'd1025,  1'b0, 16'd0,     ST_CIPHERED},
        '{FN_TEXT,   16'd1105,  1'b0, 16'd0,     ST_CIPHERED},
        '{FN_KEY,    16'd1071,  1'b1, 16'd0,     ST_KEY_STORED},
        '{FN_TEXT,   16'd1046,  1'b0, 16'd0,     ST_CIPHERED},
        '{FN_TEXT,   16'd1106,  1'b1, 16'd1106,  ST_PASSED},
        '{FN_TEXT,   16'd1077,  1'b0, 16'd0,     ST_CIPHERED},
        '{FN_TEXT,   16'd1103,  1'b0, 16'd0,     ST_CIPHERED},
        '{FN_UNUSED, 16'd1040,  1'b1, 16'd0,     ST_KEY_REJECTED},
        '{FN_CLEAR,  16'd0,     1'b1, 16'd0,     ST_KEY_STORED},
        '{FN_TEXT,   16'd1105,  1'b1, 16'd1105,  ST_NO_KEY},
        '{FN_TEXT,   16'hAAAA,  1'b1, 16'hAAAA,  ST_PASSED}
    };

    // mode settings per random segment: decrypt, keep case
    bit seg_dec  [N_SEGS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    bit seg_keep [N_SEGS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          in_data = '0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // sideband that travels with each request on the bench side
    logic              row_fixed = 1'b0;
    t_out_item         row_want = '0;

    int send_idle_pct = 23;
    int recv_idle_pct = 84;
    int cycles = 0;
    int err_count = 0;

    // cipher model state
    logic [IDX_W-1:0] key_store [KEY_MAX_DEF];
    int               key_len = 0;
    int               ring_pos = 0;
    bit               cfg_decrypt = 1'b0;
    bit               cfg_keep = 1'b0;

    t_out_item cipher_q [$];
    t_out_item exp_res;
    t_out_item got_res;

    autokey_vigenere_cyrillic_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // returns the alphabet position, or -1 for anything that is not a letter
    function automatic int alpha_index(input logic [CODE_W-1:0] code, output bit lower);
        logic [CODE_W-1:0] up;
        int                pos;
        lower = 1'b0;
        up    = code;
        pos   = -1;
        if (code == CODE_IO_UP) begin
            pos = IDX_IO;
        end else if (code == CODE_IO_LO) begin
            pos   = IDX_IO;
            lower = 1'b1;
        end else begin
            if (code >= CODE_LO_FIRST && code <= CODE_LO_LAST) begin
                lower = 1'b1;
                up    = code - CASE_OFFSET;
            end
            if (up >= CODE_UP_FIRST && up <= CODE_UP_LAST) begin
                pos = int'(up - CODE_UP_FIRST);
                if (pos >= IDX_IO)
                    pos++;
            end
        end
        return pos;
    endfunction

    function automatic logic [CODE_W-1:0] alpha_code(input int pos, input bit lower);
        logic [CODE_W-1:0] up;
        if (pos == IDX_IO)
            return lower ? CODE_IO_LO : CODE_IO_UP;
        // letters after io are shifted down by one code
        up = CODE_UP_FIRST + CODE_W'(pos < IDX_IO ? pos : pos - 1);
        return lower ? up + CASE_OFFSET : up;
    endfunction

    function automatic t_out_item cipher_step(input t_in_item req);
        t_out_item res;
        bit        lower;
        int        pos;
        int        k;
        int        c;
        res.out_code = '0;
        res.status   = ST_KEY_REJECTED;
        pos = alpha_index(req.in_code, lower);
        case (req.func)
            FN_CLEAR: begin
                key_len    = 0;
                ring_pos   = 0;
                res.status = ST_KEY_STORED;
            end
            FN_KEY: begin
                if (pos >= 0 && key_len < KEY_MAX_DEF) begin
                    key_store[key_len] = IDX_W'(pos);
                    key_len++;
                    res.status = ST_KEY_STORED;
                end
            end
            FN_TEXT: begin
                res.out_code = req.in_code;
                if (pos < 0) begin
                    res.status = ST_PASSED;
                end else if (key_len == 0) begin
                    res.status = ST_NO_KEY;
                end else begin
                    if (ring_pos >= key_len)
                        ring_pos = 0;
                    k = int'(key_store[ring_pos]);
                    if (cfg_decrypt) begin
                        c = (pos + ALPHA - k) % ALPHA;
                        key_store[ring_pos] = IDX_W'(c);
                    end else begin
                        c = (pos + k) % ALPHA;
                        key_store[ring_pos] = IDX_W'(pos);
                    end
                    ring_pos++;
                    if (ring_pos >= key_len)
                        ring_pos = 0;
                    res.out_code = alpha_code(c, lower && cfg_keep);
                    res.status   = ST_CIPHERED;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] random_letter();
        return alpha_code($urandom_range(0, ALPHA - 1), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [CODE_W-1:0] random_nonletter();
        logic [CODE_W-1:0] v;
        v = CODE_W'($urandom_range(1104, 1200));
        case ($urandom_range(0, 4))
            0: return CODE_W'($urandom_range(0, 1023));
            1: return CODE_W'($urandom_range(1026, 1039));
            2: return (v == CODE_IO_LO) ? 16'd1104 : v;
            3: return CODE_W'($urandom_range(1106, 65535));
            default: return 16'd1024;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        err_count++;
        if (err_count <= SHOW_MAX)
            $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
    endtask

    // called right after a rising edge; leaves in_valid high after acceptance
    task automatic push_request(input logic [1:0] func, input logic [CODE_W-1:0] code,
                                input logic fixed, input t_out_item want);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid        <= 1'b1;
        in_data.func    <= func;
        in_data.in_code <= code;
        row_fixed       <= fixed;
        row_want        <= want;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic send_item(input logic [1:0] func, input logic [CODE_W-1:0] code);
        push_request(func, code, 1'b0, '0);
    endtask

    // one edge first so the last accepted request is already queued
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (cipher_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DECRYPT)
            cfg_decrypt = data[0];
        else if (addr == ADDR_KEEP_CASE)
            cfg_keep = data[0];
        @(posedge i_clk);
    endtask

    // messages: usually clear, key, then a text stream; ignored requests are not counted
    task automatic run_messages(input int quota);
        int sent;
        int klen;
        int tlen;
        int pick;
        int i;
        int j;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 9) != 0) begin
                send_item(FN_CLEAR, CODE_W'($urandom));
                sent++;
            end
            // now and then fill the ring near its top, at times pushing past it
            klen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
            for (i = 0; i < klen; i++) begin
                if ($urandom_range(0, 11) == 0)
                    send_item(FN_KEY, random_nonletter());
                send_item(FN_KEY, random_letter());
                sent++;
            end
            tlen = $urandom_range(4, 40);
            for (j = 0; j < tlen; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    send_item(FN_TEXT, random_letter());
                end else if (pick < 88) begin
                    send_item(FN_TEXT, random_nonletter());
                end else if (pick < 93) begin
                    send_item(FN_KEY, random_letter());
                end else if (pick < 97) begin
                    send_item(FN_UNUSED, CODE_W'($urandom));
                    sent--;
                end else begin
                    send_item(FN_TEXT, CODE_W'($urandom));
                end
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // results are checked before the same edge's request is modeled
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_out_valid && out_ready) begin
                if (cipher_q.size() == 0) begin
                    note_mismatch("unexpected result, code", -1, int'(o_out_data.out_code));
                end else begin
                    exp_res = cipher_q.pop_front();
                    if (o_out_data.out_code !== exp_res.out_code)
                        note_mismatch("out_code", int'(exp_res.out_code),
                                      int'(o_out_data.out_code));
                    if (o_out_data.status !== exp_res.status)
                        note_mismatch("status", int'(exp_res.status), int'(o_out_data.status));
                end
            end
            if (in_valid && o_in_ready) begin
                got_res = cipher_step(in_data);
                cipher_q.push_back(row_fixed ? row_want : got_res);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int       r;
        int       s;
        t_out_item want;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings
        for (r = 0; r < N_ROWS; r++) begin
            want.out_code = plan[r].want_code;
            want.status   = plan[r].want_status;
            push_request(plan[r].func, plan[r].code, plan[r].fixed, want);
        end
        drain();

        for (s = 0; s < N_SEGS; s++) begin
            if (s == 2) begin
                send_idle_pct = 84;
                recv_idle_pct = 23;
            end else if (s == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (3) @(posedge i_clk);
            write_reg(ADDR_DECRYPT, {31'd0, seg_dec[s]});
            write_reg(ADDR_KEEP_CASE, {31'd0, seg_keep[s]});
            run_messages(SEG_ITEMS);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
